@@ rtl/gcd_pkg.sv @@
// Shared constants, tables and a helper function of the great-circle distance core.
package gcd_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int ROOT_BITS = 31;

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
  localparam logic [30:0] PI_Q29 = 31'd1686629713;
  localparam logic signed [33:0] TURN_DEG = 34'sd1509949440;
  localparam logic [31:0] RECIP_45 = 32'd3054198966;
  localparam logic [6:0] DIV_45 = 7'd45;
  localparam logic [22:0] RADIUS_RESET = 23'd6371000;

  localparam logic [2:0] ADDR_RADIUS = 3'd0;

  localparam logic [6:0] FRAC_TAB [0:44] = '{
    7'd0, 7'd2, 7'd5, 7'd8, 7'd11, 7'd14, 7'd17, 7'd19, 7'd22, 7'd25,
    7'd28, 7'd31, 7'd34, 7'd36, 7'd39, 7'd42, 7'd45, 7'd48, 7'd51, 7'd54,
    7'd56, 7'd59, 7'd62, 7'd65, 7'd68, 7'd71, 7'd73, 7'd76, 7'd79, 7'd82,
    7'd85, 7'd88, 7'd91, 7'd93, 7'd96, 7'd99, 7'd102, 7'd105, 7'd108, 7'd110,
    7'd113, 7'd116, 7'd119, 7'd122, 7'd125
  };

  localparam logic [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  function automatic logic signed [31:0] clamp_q30(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'(ONE_Q30)) begin
      r = ONE_Q30;
    end else if (v < -33'(ONE_Q30)) begin
      r = -ONE_Q30;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

@@ rtl/gcd_phase.sv @@
// Angle to turn-fraction phase converter, three register stages.
module gcd_phase (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vld_in,
  input  logic signed [32:0] angle,
  output logic               vld_out,
  output logic [31:0]        phase
);

  logic signed [33:0] ang_x;
  logic [30:0] red_next, red, red2;
  logic [62:0] prod_next;
  logic [25:0] q0;
  logic [30:0] rem_raw;
  logic [6:0] rem7;
  logic corr;
  logic [25:0] q;
  logic [6:0] rem_fix;
  logic [31:0] phase_next;
  logic [2:0] vld;

  assign ang_x = 34'(angle);

  always_comb begin
    if (ang_x >= gcd_pkg::TURN_DEG) begin
      red_next = 31'(ang_x - gcd_pkg::TURN_DEG);
    end else if (ang_x >= 34'sd0) begin
      red_next = 31'(ang_x);
    end else if (ang_x >= -gcd_pkg::TURN_DEG) begin
      red_next = 31'(ang_x + gcd_pkg::TURN_DEG);
    end else begin
      red_next = 31'(ang_x + (gcd_pkg::TURN_DEG <<< 1));
    end
  end

  assign prod_next = 63'(red) * 63'(gcd_pkg::RECIP_45);

  assign rem_raw = red2 - (31'(q0) * 31'(gcd_pkg::DIV_45));
  assign rem7 = rem_raw[6:0];
  assign corr = (rem7 >= gcd_pkg::DIV_45);
  assign q = q0 + 26'(corr);
  assign rem_fix = corr ? rem7 - gcd_pkg::DIV_45 : rem7;
  assign phase_next = {q[24:0], 7'd0} + 32'(gcd_pkg::FRAC_TAB[rem_fix[5:0]]);

  always_ff @(posedge clk) begin
    if (en) begin
      red <= red_next;
      red2 <= red;
      q0 <= prod_next[62:37];
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], vld_in};
    end
  end

  assign vld_out = vld[2];

endmodule

@@ rtl/gcd_rotate.sv @@
// Pipelined CORDIC rotation giving sine and cosine of a turn-fraction phase.
module gcd_rotate (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vld_in,
  input  logic [31:0]        phase,
  output logic               vld_out,
  output logic signed [31:0] sin_val,
  output logic signed [31:0] cos_val
);

  localparam int STEPS = gcd_pkg::CORDIC_STEPS;

  logic signed [32:0] x [0:STEPS];
  logic signed [32:0] y [0:STEPS];
  logic signed [33:0] z [0:STEPS];
  logic flip [0:STEPS];
  logic [STEPS+1:0] vld;
  logic rot_flip;
  logic [31:0] ph_adj;
  logic signed [32:0] x_fin, y_fin;

  assign rot_flip = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
  assign ph_adj = rot_flip ? phase + 32'h8000_0000 : phase;

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= gcd_pkg::CORDIC_START;
      y[0] <= '0;
      z[0] <= 34'(signed'(ph_adj));
      flip[0] <= rot_flip;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (z[i] >= 34'sd0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - 34'(gcd_pkg::ATAN_TURN[i]);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + 34'(gcd_pkg::ATAN_TURN[i]);
        end
        flip[i+1] <= flip[i];
      end
    end
  end

  assign x_fin = flip[STEPS] ? -x[STEPS] : x[STEPS];
  assign y_fin = flip[STEPS] ? -y[STEPS] : y[STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= gcd_pkg::clamp_q30(x_fin);
      sin_val <= gcd_pkg::clamp_q30(y_fin);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS:0], vld_in};
    end
  end

  assign vld_out = vld[STEPS+1];

endmodule

@@ rtl/gcd_sqrt.sv @@
// Pipelined floor square root of a Q30 value, one root bit per stage.
module gcd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vld_in,
  input  logic [30:0] val,
  output logic        vld_out,
  output logic [30:0] root
);

  localparam int NB = gcd_pkg::ROOT_BITS;

  logic [60:0] rem [0:NB];
  logic [61:0] res [0:NB];
  logic [NB:0] vld;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {val, 30'd0};
      res[0] <= '0;
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_bit
    localparam logic [61:0] BIT = 62'd1 << (2 * (NB - 1 - j));
    logic [61:0] trial;
    assign trial = res[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem[j]} >= trial) begin
          rem[j+1] <= rem[j] - 61'(trial);
          res[j+1] <= (res[j] >> 1) + BIT;
        end else begin
          rem[j+1] <= rem[j];
          res[j+1] <= res[j] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NB-1:0], vld_in};
    end
  end

  assign root = res[NB][30:0];
  assign vld_out = vld[NB];

endmodule

@@ rtl/gcd_vector.sv @@
// Pipelined CORDIC vectoring giving the angle of (x, y) in turn-fraction units.
module gcd_vector (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vld_in,
  input  logic [30:0] x_in,
  input  logic [30:0] y_in,
  output logic        vld_out,
  output logic [30:0] ang
);

  localparam int STEPS = gcd_pkg::CORDIC_STEPS;

  logic signed [33:0] x [0:STEPS];
  logic signed [33:0] y [0:STEPS];
  logic signed [33:0] z [0:STEPS];
  logic [STEPS+1:0] vld;

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= 34'(x_in);
      y[0] <= 34'(y_in);
      z[0] <= '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (y[i] > 34'sd0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + 34'(gcd_pkg::ATAN_TURN[i]);
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - 34'(gcd_pkg::ATAN_TURN[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (z[STEPS] < 34'sd0) begin
        ang <= '0;
      end else if (z[STEPS] > 34'(gcd_pkg::ONE_Q30)) begin
        ang <= 31'(gcd_pkg::ONE_Q30);
      end else begin
        ang <= z[STEPS][30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS:0], vld_in};
    end
  end

  assign vld_out = vld[STEPS+1];

endmodule

@@ rtl/great_circle_distance_core.sv @@
// Top level of the haversine great-circle distance core.
// Takes one transaction of two points (latitude and longitude in degrees times 2^22)
// per cycle when in_ready is high and returns the great-circle distance in 1/16
// meter on a sphere whose radius in meters is set through the APB register at
// address 0 (reset 6371000). The pipeline runs phase conversion, the sine/cosine
// CORDIC, the haversine products, the square roots, the arctangent CORDIC and the
// radius scaling in that order; all stages advance together and hold while the
// output register is full and not taken.
module great_circle_distance_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [29:0] first_lat,
  input  logic signed [30:0] first_lon,
  input  logic signed [29:0] second_lat,
  input  logic signed [30:0] second_lon,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [28:0]        distance,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic en;
  logic [22:0] radius;
  logic signed [32:0] dlat, dlon, lat1_x, lat2_x;
  logic [31:0] dlat_ph, dlon_ph, lat1_ph, lat2_ph;
  logic ph_vld, rot_vld;
  logic signed [31:0] s_dlat, s_dlon, c1, c2;
  logic signed [63:0] m_lat, m_lon, m_cc, m_t;
  logic [30:0] sq_lat, sq_lon, sq_lat2;
  logic signed [31:0] cc, t;
  logic signed [32:0] a_sum;
  logic [30:0] a_q, b_q;
  logic [2:0] vld_a;
  logic [30:0] root_a, root_b;
  logic root_vld, vec_vld;
  logic [30:0] z_ang;
  logic [61:0] m_pz;
  logic [31:0] pz;
  logic [54:0] m_dist;
  logic [1:0] vld_f;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcd_pkg::RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == gcd_pkg::ADDR_RADIUS) begin
      radius <= pwdata[22:0];
    end
  end

  assign prdata = (paddr == gcd_pkg::ADDR_RADIUS) ? {9'd0, radius} : 32'd0;

  assign dlat = 33'(second_lat) - 33'(first_lat);
  assign dlon = 33'(second_lon) - 33'(first_lon);
  assign lat1_x = 33'(first_lat);
  assign lat2_x = 33'(second_lat);

  gcd_phase u_ph_dlat (.clk, .rst, .en, .vld_in(in_valid && in_ready), .angle(dlat),
    .vld_out(ph_vld), .phase(dlat_ph));
  gcd_phase u_ph_dlon (.clk, .rst, .en, .vld_in(in_valid && in_ready), .angle(dlon),
    .vld_out(), .phase(dlon_ph));
  gcd_phase u_ph_lat1 (.clk, .rst, .en, .vld_in(in_valid && in_ready), .angle(lat1_x),
    .vld_out(), .phase(lat1_ph));
  gcd_phase u_ph_lat2 (.clk, .rst, .en, .vld_in(in_valid && in_ready), .angle(lat2_x),
    .vld_out(), .phase(lat2_ph));

  gcd_rotate u_rot_dlat (.clk, .rst, .en, .vld_in(ph_vld), .phase({1'b0, dlat_ph[31:1]}),
    .vld_out(rot_vld), .sin_val(s_dlat), .cos_val());
  gcd_rotate u_rot_dlon (.clk, .rst, .en, .vld_in(ph_vld), .phase({1'b0, dlon_ph[31:1]}),
    .vld_out(), .sin_val(s_dlon), .cos_val());
  gcd_rotate u_rot_lat1 (.clk, .rst, .en, .vld_in(ph_vld), .phase(lat1_ph),
    .vld_out(), .sin_val(), .cos_val(c1));
  gcd_rotate u_rot_lat2 (.clk, .rst, .en, .vld_in(ph_vld), .phase(lat2_ph),
    .vld_out(), .sin_val(), .cos_val(c2));

  assign m_lat = 64'(s_dlat) * 64'(s_dlat);
  assign m_lon = 64'(s_dlon) * 64'(s_dlon);
  assign m_cc = 64'(c1) * 64'(c2);
  assign m_t = 64'(cc) * 64'(signed'({1'b0, sq_lon}));
  assign a_sum = 33'(signed'({1'b0, sq_lat2})) + 33'(t);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_lat <= m_lat[60:30];
      sq_lon <= m_lon[60:30];
      cc <= 32'(m_cc >>> 30);
      t <= 32'(m_t >>> 30);
      sq_lat2 <= sq_lat;
      if (a_sum < 33'sd0) begin
        a_q <= '0;
        b_q <= 31'(gcd_pkg::ONE_Q30);
      end else if (a_sum > 33'(gcd_pkg::ONE_Q30)) begin
        a_q <= 31'(gcd_pkg::ONE_Q30);
        b_q <= '0;
      end else begin
        a_q <= a_sum[30:0];
        b_q <= 31'(gcd_pkg::ONE_Q30) - a_sum[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= '0;
    end else if (en) begin
      vld_a <= {vld_a[1:0], rot_vld};
    end
  end

  gcd_sqrt u_sqrt_a (.clk, .rst, .en, .vld_in(vld_a[2]), .val(a_q),
    .vld_out(root_vld), .root(root_a));
  gcd_sqrt u_sqrt_b (.clk, .rst, .en, .vld_in(vld_a[2]), .val(b_q),
    .vld_out(), .root(root_b));

  gcd_vector u_vec (.clk, .rst, .en, .vld_in(root_vld), .x_in(root_b), .y_in(root_a),
    .vld_out(vec_vld), .ang(z_ang));

  assign m_pz = 62'(z_ang) * 62'(gcd_pkg::PI_Q29) + (62'd1 << 28);
  assign m_dist = 55'(radius) * 55'(pz) + (55'd1 << 25);

  always_ff @(posedge clk) begin
    if (en) begin
      pz <= m_pz[60:29];
      distance <= m_dist[54:26];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_f <= '0;
    end else if (en) begin
      vld_f <= {vld_f[0], vec_vld};
    end
  end

  assign out_valid = vld_f[1];

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    out_valid && radius == 23'd0 |-> distance == 29'd0)
    else $error("nonzero distance with zero radius");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    vec_vld |-> z_ang <= 31'(gcd_pkg::ONE_Q30))
    else $error("central angle out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld_a) && $stable(a_q) && $stable(b_q))
    else $error("pipeline moved during stall");

endmodule
